### hw/rtl/smi_pkg.sv
// Package: constants, types and sine table for the SIREN MLP evaluator.
package smi_pkg;

  localparam int MAX_HIDDEN_DEF = 64;
  localparam int MAX_LAYERS_DEF = 4;
  localparam int WEIGHT_WORDS_DEF = 32768;
  localparam int SINE_DEPTH = 1024;
  localparam int SINE_AW = 10;
  localparam int ADDR_W = 15;
  localparam int HW_W = 7;
  localparam int HL_W = 3;
  localparam int CFG_W = 7;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_HIDDEN_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HIDDEN_LAYERS = 1'b1;
  localparam logic [31:0] TURNS_PER_Z = 32'd80105306;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // controller -> datapath commands
  typedef struct packed {
    logic load_point;
    logic acc_clear;
    logic mac_en;
    logic bias_en;
    logic act_wr;
    logic out_en;
  } dp_cmd_t;

  // sine table entry, used to fill the sine ROM
  function automatic logic [12:0] sine_entry(input int i);
    logic [63:0] u, theta, term;
    longint sum, e;
    u = (64'(i) << 30) / 64'(SINE_DEPTH);
    theta = (u * HALF_PI_Q30) >> 30;
    term = theta;
    sum = longint'(theta);
    for (int k = 1; k <= 6; k++) begin
      term = (term * theta) >> 30;
      term = (term * theta) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    e = longint'((64'(sum) + 64'(1 << 17)) >> 18);
    if (e > 4096) e = 4096;
    return 13'(e);
  endfunction

endpackage

### hw/rtl/smi_ctrl.sv
// Controller: sequences layers, neurons and weight addresses.
module smi_ctrl #(
  parameter int MAX_HIDDEN = smi_pkg::MAX_HIDDEN_DEF,
  parameter int MAX_LAYERS = smi_pkg::MAX_LAYERS_DEF,
  parameter int AW = smi_pkg::ADDR_W
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic req_type,
  input  logic [smi_pkg::HW_W-1:0] hidden_width,
  input  logic [smi_pkg::HL_W-1:0] hidden_layers,
  output logic busy,
  output logic wr_store,
  output logic [AW-1:0] waddr,
  output logic [$clog2(2*MAX_HIDDEN)-1:0] act_raddr,
  output logic [$clog2(2*MAX_HIDDEN)-1:0] act_waddr,
  output logic [1:0] pt_sel,
  output logic use_pt,
  output smi_pkg::dp_cmd_t cmd
);
  import smi_pkg::*;

  localparam int NW = $clog2(MAX_HIDDEN + 1);
  localparam int IW = $clog2(MAX_HIDDEN);
  localparam int LW = $clog2(MAX_LAYERS + 2);
  localparam int BW = $clog2(2*MAX_HIDDEN);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MAC  = 7'b0000010,
    S_BIAS = 7'b0000100,
    S_SUM  = 7'b0001000,
    S_SIN  = 7'b0010000,
    S_OUT  = 7'b0100000,
    S_WAIT = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic [NW-1:0] h, i, j, nin;
  logic [LW-1:0] nl, layer;
  logic src;
  logic [AW-1:0] base, wa;
  logic [2:0] pipe;
  logic out_layer;

  always_comb begin
    if (hidden_width == '0) h = NW'(1);
    else if (32'(hidden_width) > MAX_HIDDEN) h = NW'(MAX_HIDDEN);
    else h = NW'(hidden_width);
    if (32'(hidden_layers) > MAX_LAYERS) nl = LW'(MAX_LAYERS);
    else nl = LW'(hidden_layers);
  end

  assign busy = (state != S_IDLE);
  assign wr_store = start && !busy && !req_type;
  assign out_layer = (layer == nl + LW'(1));
  assign use_pt = (layer == '0);
  assign pt_sel = j[1:0];
  assign waddr = wa;
  assign act_raddr = {src, j[IW-1:0]};
  assign act_waddr = {~src, i[IW-1:0]};
  assign nin = use_pt ? NW'(3) : h;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start && req_type) state_next = S_MAC;
      S_MAC:  if (j == nin - NW'(1)) state_next = S_BIAS;
      S_BIAS: state_next = S_SUM;
      S_SUM:  if (pipe == 3'd0) state_next = out_layer ? S_OUT : S_SIN;
      S_SIN:  state_next = S_MAC;
      S_OUT:  state_next = S_WAIT;
      S_WAIT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i <= '0; j <= '0; layer <= '0; src <= 1'b0; base <= '0; wa <= '0; pipe <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          i <= '0; j <= '0; layer <= '0; src <= 1'b0; base <= '0; wa <= '0;
        end
        S_MAC: begin
          if (j == nin - NW'(1)) begin
            j <= '0;
            // output layer has a single row, its bias follows its H weights
            if (out_layer) wa <= AW'(base + AW'(nin));
            else wa <= AW'(base + AW'(nin) * AW'(h) + AW'(i));
          end else begin
            j <= j + NW'(1);
            wa <= wa + AW'(1);
          end
        end
        S_BIAS: pipe <= 3'd3;
        S_SUM: if (pipe != 3'd0) pipe <= pipe - 3'd1;
        S_SIN: begin
          if (i == h - NW'(1)) begin
            i <= '0;
            base <= AW'(base + AW'(nin) * AW'(h) + AW'(h));
            wa <= AW'(base + AW'(nin) * AW'(h) + AW'(h));
            layer <= layer + LW'(1);
            src <= ~src;
          end else begin
            i <= i + NW'(1);
            wa <= AW'(base + AW'(nin) * AW'(i + NW'(1)));
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    cmd.load_point = start && !busy && req_type;
    cmd.acc_clear = (state == S_IDLE) || (state == S_SIN);
    cmd.mac_en = (state == S_MAC);
    cmd.bias_en = (state == S_BIAS);
    cmd.act_wr = (state == S_SIN);
    cmd.out_en = (state == S_OUT);
  end

  ap_out_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.out_en |=> busy) else $error("output strobe not followed by wait");
  ap_no_wr_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !wr_store) else $error("store write while busy");
  ap_j_range: assert property (@(posedge clk) disable iff (rst)
    state == S_MAC |-> j < nin) else $error("input index out of range");
endmodule

### hw/rtl/smi_datapath.sv
// Datapath: weight store, activation buffer, MAC, sine unit, output rounding.
module smi_datapath #(
  parameter int MAX_HIDDEN = smi_pkg::MAX_HIDDEN_DEF,
  parameter int WEIGHT_WORDS = smi_pkg::WEIGHT_WORDS_DEF,
  parameter int AW = smi_pkg::ADDR_W
) (
  input  logic clk,
  input  logic rst,
  input  smi_pkg::dp_cmd_t cmd,
  input  logic wr_store,
  input  logic [AW-1:0] weight_addr,
  input  logic signed [15:0] weight_value,
  input  logic signed [15:0] x_coord,
  input  logic signed [15:0] y_coord,
  input  logic signed [15:0] z_coord,
  input  logic [AW-1:0] waddr,
  input  logic [$clog2(2*MAX_HIDDEN)-1:0] act_raddr,
  input  logic [$clog2(2*MAX_HIDDEN)-1:0] act_waddr,
  input  logic [1:0] pt_sel,
  input  logic use_pt,
  output logic done,
  output logic signed [15:0] distance
);
  import smi_pkg::*;

  localparam int SAW = $clog2(WEIGHT_WORDS);
  localparam int ABW = $clog2(2*MAX_HIDDEN);
  localparam int SIW = $clog2(SINE_DEPTH + 1);

  logic signed [15:0] wmem [WEIGHT_WORDS];
  logic signed [15:0] amem [2**ABW];
  logic [12:0] sine_rom [SINE_DEPTH+1];
  logic signed [15:0] px, py, pz, wq, aq, pq, a_op;
  logic signed [31:0] prod;
  logic signed [31:0] acc;
  logic signed [33:0] sum;
  logic signed [63:0] turns;
  logic [23:0] frac;
  logic [11:0] phase;
  logic [SINE_AW-1:0] r;
  logic [SIW-1:0] sidx;
  logic [12:0] tval;
  logic sneg;
  logic [1:0] quad;
  logic signed [15:0] sval;
  logic mv1, mv2, bv1, bv2;
  logic signed [32:0] rnd;
  logic signed [20:0] q;

  initial begin
    for (int k = 0; k <= SINE_DEPTH; k++) sine_rom[k] = sine_entry(k);
  end

  always_ff @(posedge clk) begin
    if (wr_store && 32'(weight_addr) < WEIGHT_WORDS) wmem[SAW'(weight_addr)] <= weight_value;
    wq <= wmem[SAW'(waddr)];
    aq <= amem[act_raddr];
    if (cmd.act_wr) amem[act_waddr] <= sval;
    if (cmd.load_point) begin
      px <= x_coord; py <= y_coord; pz <= z_coord;
    end
  end

  always_comb begin
    unique case (pt_sel)
      2'd0: pq = px;
      2'd1: pq = py;
      default: pq = pz;
    endcase
  end

  logic use_pt_q;
  logic signed [15:0] pq_q;
  always_ff @(posedge clk) begin
    pq_q <= pq;
    use_pt_q <= use_pt;
    prod <= a_op * wq;
  end
  assign a_op = use_pt_q ? pq_q : aq;

  always_ff @(posedge clk) begin
    if (rst) begin
      mv1 <= 1'b0; mv2 <= 1'b0; bv1 <= 1'b0; bv2 <= 1'b0;
    end else begin
      mv1 <= cmd.mac_en; mv2 <= mv1;
      bv1 <= cmd.bias_en; bv2 <= bv1;
    end
  end

  always_comb begin
    if (bv2) sum = 34'(acc) + (34'(wq) <<< 12);
    else sum = 34'(acc) + 34'(prod);
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clear) acc <= '0;
    else if (mv2 || bv2) begin
      if (sum > 34'sh7FFFFFFF) acc <= 32'sh7FFFFFFF;
      else if (sum < -34'sh80000000) acc <= 32'sh80000000;
      else acc <= sum[31:0];
    end
  end

  always_ff @(posedge clk) turns <= 64'(acc) * $signed({1'b0, TURNS_PER_Z});

  assign frac = turns[47:24];
  assign phase = frac[23:12];
  assign quad = phase[11:10];
  assign r = phase[9:0];
  assign sidx = quad[0] ? SIW'(SINE_DEPTH) - SIW'(r) : SIW'(r);

  always_ff @(posedge clk) begin
    tval <= sine_rom[sidx];
    sneg <= quad[1];
  end

  assign sval = sneg ? -$signed({3'b0, tval}) : $signed({3'b0, tval});

  assign rnd = 33'(acc) + 33'sd2048;
  assign q = rnd[32:12];

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= cmd.out_en;
    if (cmd.out_en) begin
      if (q > 21'sd32767) distance <= 16'sh7FFF;
      else if (q < -21'sd32768) distance <= 16'sh8000;
      else distance <= q[15:0];
    end
  end

  ap_sat: assert property (@(posedge clk) disable iff (rst)
    bv2 |-> !mv2) else $error("bias and product added together");
  ap_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.out_en)) else $error("stray done");
  ap_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than one cycle");
endmodule

### hw/rtl/siren_mlp_inference_top.sv
// Top level of the SIREN MLP evaluator.
// Usage:
//  A transaction is accepted at a rising edge with start high and busy low.
//  req_type 0 writes weight_value at weight_addr; busy stays low, so writes
//  can follow each other every cycle.
//  req_type 1 evaluates (x_coord,y_coord,z_coord); busy stays high until
//  done has pulsed for one cycle with distance valid.
//  Weight store layout: per layer row-major weights then biases.
//  Timing: the single shared MAC and sine pipeline process one neuron at a
//  time (nin = 3 in the first layer, H after it). busy drops in the cycle
//  after done is high, and a new point is accepted only once busy is low.
//  Configuration: cfg_we writes hidden_width (index 0) or hidden_layers
//  (index 1); the user must write them only while idle, as the block
//  itself does not enforce this.
//  Reset clears control state; weight store contents are undefined until
//  written. The receiver cannot stall: done is a one-cycle strobe.
module siren_mlp_inference_top #(
  parameter int MAX_HIDDEN = smi_pkg::MAX_HIDDEN_DEF,
  parameter int MAX_LAYERS = smi_pkg::MAX_LAYERS_DEF,
  parameter int WEIGHT_WORDS = smi_pkg::WEIGHT_WORDS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic req_type,
  input  logic [smi_pkg::ADDR_W-1:0] weight_addr,
  input  logic signed [15:0] weight_value,
  input  logic signed [15:0] x_coord,
  input  logic signed [15:0] y_coord,
  input  logic signed [15:0] z_coord,
  output logic done,
  output logic signed [15:0] distance,
  input  logic cfg_we,
  input  logic [smi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [smi_pkg::CFG_W-1:0] cfg_data
);
  import smi_pkg::*;

  logic [HW_W-1:0] hidden_width;
  logic [HL_W-1:0] hidden_layers;
  dp_cmd_t cmd;
  logic wr_store, use_pt;
  logic [ADDR_W-1:0] waddr;
  logic [$clog2(2*MAX_HIDDEN)-1:0] act_raddr, act_waddr;
  logic [1:0] pt_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      hidden_width <= HW_W'(64);
      hidden_layers <= HL_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HIDDEN_WIDTH: hidden_width <= cfg_data[HW_W-1:0];
        REG_HIDDEN_LAYERS: hidden_layers <= cfg_data[HL_W-1:0];
        default: ;
      endcase
    end
  end

  smi_ctrl #(.MAX_HIDDEN(MAX_HIDDEN), .MAX_LAYERS(MAX_LAYERS)) u_ctrl (
    .clk, .rst, .start, .req_type, .hidden_width, .hidden_layers, .busy,
    .wr_store, .waddr, .act_raddr, .act_waddr, .pt_sel, .use_pt, .cmd
  );

  smi_datapath #(.MAX_HIDDEN(MAX_HIDDEN), .WEIGHT_WORDS(WEIGHT_WORDS)) u_dp (
    .clk, .rst, .cmd, .wr_store, .weight_addr, .weight_value, .x_coord, .y_coord,
    .z_coord, .waddr, .act_raddr, .act_waddr, .pt_sel, .use_pt, .done, .distance
  );
endmodule
